### src/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg: shared types and constants of the row box blur
// Beat structs, configuration struct, controller command and status
// groups, register codes and the channel scaling function.
// ----------------------------------------------------------------------------
package rbb_pkg;

	localparam int CHAN_N      = 4;
	localparam int CHAN_W      = 8;
	localparam int PIX_W       = CHAN_N * CHAN_W;
	localparam int REACH_W     = 6;
	localparam int REACH_N     = 1 << REACH_W;
	localparam int SCALE_W     = 25;
	localparam int SUM_W       = 15;
	localparam int PROD_W      = SUM_W + SCALE_W;
	localparam int SCALE_SHIFT = 24;
	localparam int CNT_W       = 6;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1 << SCALE_SHIFT);
	localparam logic [PROD_W:0]    ROUND_HALF  = (PROD_W+1)'(1 << (SCALE_SHIFT - 1));

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_LEFT_REACH  = 2'd0;
	localparam logic [1:0] REG_RIGHT_REACH = 2'd1;
	localparam logic [1:0] REG_RECIP_SCALE = 2'd2;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             row_end;
	} rbb_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             row_done;
		logic             run_last;
	} rbb_out_t;

	typedef struct packed {
		logic [REACH_W-1:0] left_reach;
		logic [REACH_W-1:0] right_reach;
		logic [SCALE_W-1:0] recip_scale;
	} rbb_cfg_t;

	typedef struct packed {
		logic take;
		logic issue;
		logic emit;
		logic step_in;
		logic row_clear;
	} rbb_cmd_t;

	typedef struct packed {
		logic row_last;
		logic emit_due;
		logic flush_done;
		logic out_free;
	} rbb_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCALE
	} rbb_state_t;

	// Rounds a channel product down by the scale shift and clamps it to 8 bits.
	function automatic logic [CHAN_W-1:0] scale_chan(input logic [PROD_W-1:0] prod);
		logic [PROD_W:0] rnd;
		rnd = {1'b0, prod} + ROUND_HALF;
		if (|rnd[PROD_W:SCALE_SHIFT+CHAN_W]) begin
			return '1;
		end
		return rnd[SCALE_SHIFT +: CHAN_W];
	endfunction

endpackage

### src/rbb_ram.sv
// ----------------------------------------------------------------------------
// rbb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### src/rbb_regs.sv
// ----------------------------------------------------------------------------
// rbb_regs: configuration registers
// APB-style register file holding the window reaches and the scale factor.
// ----------------------------------------------------------------------------
module rbb_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [rbb_pkg::ADDR_W-1:0] paddr,
	input  logic [rbb_pkg::DATA_W-1:0] pwdata,
	output logic [rbb_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output rbb_pkg::rbb_cfg_t         cfg
);
	import rbb_pkg::*;

	rbb_cfg_t   cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_reach  <= '0;
			cfg_q.right_reach <= '0;
			cfg_q.recip_scale <= SCALE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LEFT_REACH:  cfg_q.left_reach  <= pwdata[REACH_W-1:0];
				REG_RIGHT_REACH: cfg_q.right_reach <= pwdata[REACH_W-1:0];
				REG_RECIP_SCALE: cfg_q.recip_scale <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LEFT_REACH:  prdata = DATA_W'(cfg_q.left_reach);
			REG_RIGHT_REACH: prdata = DATA_W'(cfg_q.right_reach);
			REG_RECIP_SCALE: prdata = DATA_W'(cfg_q.recip_scale);
			default:         prdata = '0;
		endcase
	end

endmodule

### src/rbb_ctrl.sv
// ----------------------------------------------------------------------------
// rbb_ctrl: blur sequencer
// Takes one pixel at a time and walks the datapath through each result
// that the pixel causes, including the flush at row end.
// ----------------------------------------------------------------------------
module rbb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  rbb_pkg::rbb_stat_t stat,
	output rbb_pkg::rbb_cmd_t  cmd
);
	import rbb_pkg::*;

	rbb_state_t state_q;
	rbb_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pix_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.row_last || stat.emit_due) begin
					state_d = ST_SCALE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCALE: begin
				if (stat.out_free) begin
					if (stat.row_last && !stat.flush_done) begin
						state_d = ST_DECIDE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		pix_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				pix_stall = 1'b0;
				cmd.take  = pix_valid;
			end
			ST_DECIDE: begin
				if (stat.row_last || stat.emit_due) begin
					cmd.issue = 1'b1;
				end else begin
					cmd.step_in = 1'b1;
				end
			end
			ST_SCALE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (!stat.row_last) begin
						cmd.step_in = 1'b1;
					end else if (stat.flush_done) begin
						cmd.row_clear = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

### src/rbb_datapath.sv
// ----------------------------------------------------------------------------
// rbb_datapath: window store, running sums, scaling and result register
// Holds the pixel window in RAM, the four channel sums, the row positions
// and the output register, all stepped by the sequencer's commands.
// ----------------------------------------------------------------------------
module rbb_datapath #(
	parameter int WINDOW_DEPTH = 128,
	parameter int MAX_ROW      = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rbb_pkg::rbb_cmd_t  cmd,
	output rbb_pkg::rbb_stat_t stat,
	input  rbb_pkg::rbb_cfg_t  cfg,
	input  rbb_pkg::rbb_in_t   pix,
	output rbb_pkg::rbb_out_t  res,
	output logic               res_valid,
	input  logic               res_stall
);
	import rbb_pkg::*;

	localparam int SW = $clog2(WINDOW_DEPTH);
	localparam int PW = $clog2(MAX_ROW);
	localparam int CW = (PW > REACH_W) ? PW : REACH_W;
	localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW_DEPTH - 1);
	localparam logic [PW-1:0] POS_LAST  = PW'(MAX_ROW - 1);
	localparam logic [SW:0]   DEPTH_EXT = (SW+1)'(WINDOW_DEPTH);

	logic [SUM_W-1:0]  sums_q [CHAN_N];
	logic [PROD_W-1:0] prod_q [CHAN_N];
	logic [PW-1:0]     in_pos_q;
	logic [PW-1:0]     out_pos_q;
	logic [SW-1:0]     in_slot_q;
	logic [SW-1:0]     out_slot_q;
	logic [CNT_W-1:0]  emit_cnt_q;
	logic              row_last_q;
	logic              res_valid_q;
	rbb_out_t          res_q;

	logic [SW-1:0]    left_mod_tab [REACH_N];
	logic [SW-1:0]    left_mod;
	logic [SW:0]      tail_wide;
	logic [SW-1:0]    tail_slot;
	logic [PIX_W-1:0] old_px;
	logic [PW-1:0]    pos_gap;
	logic             out_ge_left;
	logic             flush_done;
	logic [PIX_W-1:0] blurred;

	// Left reach taken modulo the window depth, one entry per reach value.
	for (genvar g = 0; g < REACH_N; g++) begin : g_left_mod
		assign left_mod_tab[g] = SW'(g % WINDOW_DEPTH);
	end

	assign left_mod = left_mod_tab[cfg.left_reach];

	// Slot of the pixel leaving the window: (out - left) modulo depth.
	always_comb begin
		if (out_slot_q >= left_mod) begin
			tail_wide = {1'b0, out_slot_q} - {1'b0, left_mod};
		end else begin
			tail_wide = {1'b0, out_slot_q} + DEPTH_EXT - {1'b0, left_mod};
		end
	end

	assign tail_slot = tail_wide[SW-1:0];

	rbb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk     (clk),
		.wr_en   (cmd.take),
		.wr_addr (in_slot_q),
		.wr_data (pix.pixel_in),
		.rd_en   (cmd.issue),
		.rd_addr (tail_slot),
		.rd_data (old_px)
	);

	assign pos_gap     = in_pos_q - out_pos_q;
	assign out_ge_left = CW'(out_pos_q) >= CW'(cfg.left_reach);
	assign flush_done  = (out_pos_q == in_pos_q) || (emit_cnt_q == '1);

	assign stat.row_last   = row_last_q;
	assign stat.emit_due   = CW'(pos_gap) >= CW'(cfg.right_reach);
	assign stat.flush_done = flush_done;
	assign stat.out_free   = !res_valid_q || !res_stall;

	always_comb begin
		for (int k = 0; k < CHAN_N; k++) begin
			blurred[k*CHAN_W +: CHAN_W] = scale_chan(prod_q[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CHAN_N; k++) begin
				sums_q[k] <= '0;
			end
		end else if (cmd.row_clear) begin
			for (int k = 0; k < CHAN_N; k++) begin
				sums_q[k] <= '0;
			end
		end else if (cmd.take) begin
			for (int k = 0; k < CHAN_N; k++) begin
				sums_q[k] <= sums_q[k] + SUM_W'(pix.pixel_in[k*CHAN_W +: CHAN_W]);
			end
		end else if (cmd.emit && out_ge_left) begin
			for (int k = 0; k < CHAN_N; k++) begin
				sums_q[k] <= sums_q[k] - SUM_W'(old_px[k*CHAN_W +: CHAN_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q   <= '0;
			in_slot_q  <= '0;
			out_pos_q  <= '0;
			out_slot_q <= '0;
			emit_cnt_q <= '0;
			row_last_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				row_last_q <= pix.row_end || (in_pos_q == POS_LAST);
				emit_cnt_q <= '0;
			end else if (cmd.emit) begin
				emit_cnt_q <= emit_cnt_q + CNT_W'(1);
			end
			if (cmd.row_clear) begin
				in_pos_q   <= '0;
				in_slot_q  <= '0;
				out_pos_q  <= '0;
				out_slot_q <= '0;
			end else begin
				if (cmd.step_in) begin
					in_pos_q  <= in_pos_q + PW'(1);
					in_slot_q <= (in_slot_q == SLOT_LAST) ? '0 : in_slot_q + SW'(1);
				end
				if (cmd.emit) begin
					out_pos_q  <= out_pos_q + PW'(1);
					out_slot_q <= (out_slot_q == SLOT_LAST) ? '0 : out_slot_q + SW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			for (int k = 0; k < CHAN_N; k++) begin
				prod_q[k] <= PROD_W'(sums_q[k]) * PROD_W'(cfg.recip_scale);
			end
		end
		if (cmd.emit) begin
			res_q.pixel_out <= blurred;
			res_q.row_done  <= row_last_q && flush_done;
			res_q.run_last  <= !row_last_q || flush_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

### src/row_box_blur_argb.sv
// ----------------------------------------------------------------------------
// row_box_blur_argb: one-dimensional sliding-window box blur over ARGB rows
// A pixel is taken while the sequencer is idle and is blocked until the
// sequencer has finished every result it causes; each result passes the
// window RAM read and the registered channel multiply, then the result
// register. Reset clears the sums, positions and handshake state.
// ----------------------------------------------------------------------------
module row_box_blur_argb #(
	parameter int WINDOW_DEPTH = 128,
	parameter int MAX_ROW      = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Pixel beats in.
	input  logic                       pix_valid,
	output logic                       pix_stall,
	input  rbb_pkg::rbb_in_t           pix,
	// Result beats out.
	output logic                       res_valid,
	input  logic                       res_stall,
	output rbb_pkg::rbb_out_t          res,
	// Configuration port.
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rbb_pkg::ADDR_W-1:0] paddr,
	input  logic [rbb_pkg::DATA_W-1:0] pwdata,
	output logic [rbb_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import rbb_pkg::*;

	// The window RAM holds the row pixels at position modulo WINDOW_DEPTH.
	// Its contents are not cleared at reset: a slot's data is only used
	// after the pixel at that position has been written, so the block is
	// ready to take beats in the first cycle after reset.
	//
	// Each pixel is written to the RAM and added to the four channel sums
	// when it is taken. If the centre pixel's right neighbor count has been
	// reached, or the row ends, the sequencer reads the slot of the pixel
	// that leaves the window and multiplies the sums by the scale factor in
	// the same cycle. Once the output is free, the scale state rounds and
	// clamps each channel into the result register and removes the leaving
	// pixel from the sums. At row end this repeats for every result still
	// owed, then the sums and positions return to zero.

	rbb_cfg_t  cfg;
	rbb_cmd_t  cmd;
	rbb_stat_t stat;

	rbb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	rbb_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.MAX_ROW      (MAX_ROW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg       (cfg),
		.pix       (pix),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

endmodule

### src/rbb_checker.sv
// ----------------------------------------------------------------------------
// rbb_checker: port-level checks of the row box blur
// Watches the handshakes and result flags on the top level's ports.
// ----------------------------------------------------------------------------
module rbb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_stall,
	input logic              res_valid,
	input logic              res_stall,
	input rbb_pkg::rbb_out_t res
);
	import rbb_pkg::*;

	// A result beat that is held back stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result beat dropped while stalled");

	// A held result beat keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("result payload changed while stalled");

	// The block works on one pixel at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |=> pix_stall)
		else $error("pixel taken while the previous one is in work");

	// The final result of a row is always the last one its pixel causes.
	a_row_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res.row_done || res.run_last))
		else $error("row end flagged on a result that is not the last");

endmodule

bind row_box_blur_argb rbb_checker u_rbb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

### bench/row_box_blur_argb_tb.sv
// ----------------------------------------------------------------------------
// row_box_blur_argb_tb: self-checking bench for the ARGB row box blur
// Pixel beats go in through the valid/stall channel while result beats are
// drained with random stalls. A behavioral copy of the blur tracks the
// window, the channel sums and both row positions, and every result beat is
// compared field by field with the oldest predicted beat. Named tests cover
// the reset settings, extreme reaches and scales, the longest flush,
// settings changed in the middle of a row, and a randomized run of rows.
// ----------------------------------------------------------------------------
module row_box_blur_argb_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import rbb_pkg::*;

	localparam int WINDOW    = 128;
	localparam int WIN_W     = $clog2(WINDOW);
	localparam int ROW_LIMIT = 4096;
	// A flush never returns more beats than this for a single pixel.
	localparam int FLUSH_MAX = 64;
	// Cycles with no beat accepted on either channel before the run is abandoned.
	localparam int STALL_LIMIT = 4000;
	// Cycles the block may still be busy after its last result beat.
	localparam int TAIL_CYCLES = 4;
	localparam longint unsigned HALF_LSB = 64'd1 << (SCALE_SHIFT - 1);

	// Block ports. Every input starts at a known value.
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              pix_valid = 1'b0;
	logic              pix_stall;
	rbb_in_t           pix       = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	rbb_out_t          res;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// When set, neither side idles: this gives the long back-to-back stretch.
	logic calm = 1'b0;

	int mismatch_count = 0;
	int quiet_cycles   = 0;

	// Predicted result beats, oldest first.
	rbb_out_t owed_results[$];

	// Behavioral copy of the blur: window, sums, positions and settings.
	logic [PIX_W-1:0]   row_pixels [WINDOW] = '{default: '0};
	logic [SUM_W-1:0]   chan_sum   [CHAN_N] = '{default: '0};
	int unsigned        next_in  = 0;
	int unsigned        next_out = 0;
	logic [REACH_W-1:0] cfg_left  = '0;
	logic [REACH_W-1:0] cfg_right = '0;
	logic [SCALE_W-1:0] cfg_scale = SCALE_RESET;

	row_box_blur_argb #(
		.WINDOW_DEPTH(WINDOW),
		.MAX_ROW     (ROW_LIMIT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Blur prediction
	// ------------------------------------------------------------------------

	// Scales the current window sums into one packed pixel. The product keeps
	// its full width, so large sums or scales saturate instead of wrapping.
	function automatic logic [PIX_W-1:0] blurred_now();
		logic [PIX_W-1:0] px;
		longint unsigned  v;
		px = '0;
		for (int k = 0; k < CHAN_N; k++) begin
			v = 64'(chan_sum[k]) * 64'(cfg_scale);
			v = (v + HALF_LSB) >> SCALE_SHIFT;
			if (v > 255) begin
				v = 255;
			end
			px[CHAN_W*k +: CHAN_W] = v[CHAN_W-1:0];
		end
		return px;
	endfunction

	// Queues the blurred pixel at the output position, then takes the pixel
	// that leaves the window out of the sums. The sums wrap at their width.
	task automatic emit_blurred(input logic done);
		rbb_out_t         r;
		logic [PIX_W-1:0] gone;
		r.pixel_out = blurred_now();
		r.row_done  = done;
		r.run_last  = 1'b0;
		owed_results.push_back(r);
		if (next_out >= cfg_left) begin
			gone = row_pixels[WIN_W'((next_out - cfg_left) % WINDOW)];
			for (int k = 0; k < CHAN_N; k++) begin
				chan_sum[k] = chan_sum[k] - SUM_W'(gone[CHAN_W*k +: CHAN_W]);
			end
		end
		next_out++;
	endtask

	// Works out every result beat that one accepted pixel beat causes.
	task automatic predict_blur(input rbb_in_t item);
		int unsigned pos;
		logic        last;
		int          n;
		rbb_out_t    r;
		pos  = next_in;
		last = item.row_end;
		n    = 0;
		// A row that reaches the length limit ends there, flag or not.
		if (pos + 1 >= ROW_LIMIT) begin
			last = 1'b1;
		end
		row_pixels[WIN_W'(pos % WINDOW)] = item.pixel_in;
		for (int k = 0; k < CHAN_N; k++) begin
			chan_sum[k] = chan_sum[k] + SUM_W'(item.pixel_in[CHAN_W*k +: CHAN_W]);
		end
		if (!last) begin
			if (pos - next_out >= cfg_right) begin
				emit_blurred(1'b0);
				n++;
			end
			next_in = pos + 1;
		end else begin
			while (next_out <= pos && n < FLUSH_MAX) begin
				emit_blurred(next_out == pos || n == FLUSH_MAX - 1);
				n++;
			end
			for (int k = 0; k < CHAN_N; k++) begin
				chan_sum[k] = '0;
			end
			next_in  = 0;
			next_out = 0;
		end
		// The final beat of this pixel carries the run marker.
		if (n > 0) begin
			r = owed_results.pop_back();
			r.run_last = 1'b1;
			owed_results.push_back(r);
		end
	endtask

	// ------------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------------

	// Sends one pixel beat, after random idle cycles, and holds it until the
	// block takes it. Valid stays high on return so that a following beat can
	// go out back to back; settle_block lowers it.
	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic last);
		rbb_in_t item;
		item.pixel_in = px;
		item.row_end  = last;
		while (!calm && $urandom_range(99) < 35) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= item;
		@(posedge clk);
		while (pix_stall) begin
			@(posedge clk);
		end
		predict_blur(item);
	endtask

	// Stops sending and waits until every predicted beat has come back, plus
	// the cycles the block may still spend on a pixel that caused no beat.
	task automatic settle_block();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// One register write: setup cycle, then access cycle until pready. The
	// trailing cycle with psel low keeps back-to-back writes apart.
	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		case (idx)
			REG_LEFT_REACH:  cfg_left  = value[REACH_W-1:0];
			REG_RIGHT_REACH: cfg_right = value[REACH_W-1:0];
			REG_RECIP_SCALE: cfg_scale = value[SCALE_W-1:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_blur(input int left, input int right, input int unsigned scale);
		write_reg(REG_LEFT_REACH, DATA_W'(left));
		write_reg(REG_RIGHT_REACH, DATA_W'(right));
		write_reg(REG_RECIP_SCALE, DATA_W'(scale));
	endtask

	// Reciprocal of the kernel size as software would program it.
	function automatic int unsigned kernel_scale(input int left, input int right);
		return SCALE_RESET / (left + right + 1);
	endfunction

	// Mostly random pixels, with black, white and single saturated channels.
	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2:       return PIX_W'(32'hFF << (CHAN_W * $urandom_range(CHAN_N - 1)));
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset settings: a one-pixel kernel at unit scale passes pixels through.
	task automatic test_reset_settings();
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'h80FF_017F, 1'b1);
		// A row of a single pixel.
		send_pixel(32'h1234_5678, 1'b1);
		settle_block();
	endtask

	// Widest window: short rows are flushed whole at row end, unit scale
	// saturates every channel, and a zero scale gives black.
	task automatic test_extreme_reach();
		set_blur(REACH_N - 1, REACH_N - 1, SCALE_RESET);
		repeat (5) send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b1);
		settle_block();
		set_blur(REACH_N - 1, REACH_N - 1, kernel_scale(REACH_N - 1, REACH_N - 1));
		repeat (4) send_pixel($urandom, 1'b0);
		send_pixel($urandom, 1'b1);
		settle_block();
		write_reg(REG_RECIP_SCALE, '0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b1);
		settle_block();
	endtask

	// With the widest right reach the output lags the input as far as it
	// can, so the row end flushes the largest run of beats one pixel causes.
	task automatic test_longest_flush();
		set_blur(0, REACH_N - 1, kernel_scale(0, REACH_N - 1));
		for (int i = 0; i < REACH_N + 5; i++) begin
			send_pixel(pick_pixel(), i == REACH_N + 4);
		end
		// The next pixel starts a fresh row.
		send_pixel(32'hA5A5_5A5A, 1'b1);
		settle_block();
	endtask

	// Settings changed while a row is open: the sums follow the add and
	// subtract rule literally and may wrap.
	task automatic test_midrow_settings();
		set_blur(0, 3, kernel_scale(0, 3));
		repeat (10) send_pixel(32'hFFFF_FFFF, 1'b0);
		settle_block();
		// Lowering the right reach makes owed beats come out one per pixel;
		// raising the left reach above the output position stops subtracting.
		set_blur(REACH_N - 1, 0, kernel_scale(REACH_N - 1, 0));
		repeat (8) send_pixel(pick_pixel(), 1'b0);
		settle_block();
		set_blur(0, REACH_N - 1, SCALE_RESET);
		repeat (9) send_pixel(pick_pixel(), 1'b0);
		settle_block();
		set_blur(5, 5, kernel_scale(5, 5));
		send_pixel(pick_pixel(), 1'b1);
		settle_block();
	endtask

	// Randomized rows in phases of fixed settings. Most rows are short, a
	// few are long; now and then row_end comes early, and a phase may end in
	// the middle of a row so the next settings take over mid-row.
	task automatic test_random_rows();
		int left;
		int right;
		int len;
		int budget;
		int unsigned scale;
		for (int phase = 0; phase < 12; phase++) begin
			// Pause until everything owed is back before touching registers.
			settle_block();
			case (phase % 4)
				0: begin
					left  = $urandom_range(1) ? REACH_N - 1 : 0;
					right = $urandom_range(1) ? REACH_N - 1 : 0;
				end
				1: begin
					left  = $urandom_range(4);
					right = $urandom_range(4);
				end
				default: begin
					left  = $urandom_range(REACH_N - 1);
					right = $urandom_range(REACH_N - 1);
				end
			endcase
			case ($urandom_range(5))
				0:       scale = SCALE_RESET;
				1:       scale = 0;
				2:       scale = $urandom_range(SCALE_RESET, 0);
				default: scale = kernel_scale(left, right);
			endcase
			set_blur(left, right, scale);
			calm   = (phase == 5);
			budget = (phase == 5) ? 70 : 21;
			while (budget > 0) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(150, 40) : $urandom_range(24, 1);
				for (int i = 0; i < len && budget > 0; i++) begin
					send_pixel(pick_pixel(), i == len - 1 || $urandom_range(19) == 0);
					budget--;
				end
			end
		end
		calm = 1'b0;
		settle_block();
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic flag_mismatch(input string what, input logic [PIX_W-1:0] got,
			input logic [PIX_W-1:0] want);
		mismatch_count++;
		$display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
	endtask

	// The receiver stalls at random except in the calm stretch.
	always @(posedge clk) begin
		res_stall <= !calm && ($urandom_range(99) < 35);
	end

	// Every accepted result beat is matched against the oldest prediction.
	always @(posedge clk) begin : check_results
		rbb_out_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (owed_results.size() == 0) begin
				flag_mismatch("unexpected result beat", res.pixel_out, '0);
			end else begin
				want = owed_results.pop_front();
				if (res.pixel_out !== want.pixel_out) begin
					flag_mismatch("pixel_out", res.pixel_out, want.pixel_out);
				end
				if (res.row_done !== want.row_done) begin
					flag_mismatch("row_done", PIX_W'(res.row_done), PIX_W'(want.row_done));
				end
				if (res.run_last !== want.run_last) begin
					flag_mismatch("run_last", PIX_W'(res.run_last), PIX_W'(want.run_last));
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no beat on either channel means
	// the block has hung or owes beats it will never deliver.
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_extreme_reach();
		test_longest_flush();
		test_midrow_settings();
		test_random_rows();
		// Catch any stray beat that shows up after the last prediction.
		repeat (2 * TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
